[design/vcac_pkg.sv]
// Shared types and constants of the custom-alphabet Vigenere cipher block.
// Holds function codes, register indexes, the queue entry and config structs.
// No dependencies; every other design file but vcac_channels imports it.
`timescale 1ns / 1ps

package vcac_pkg;

    localparam logic [1:0] FUNC_ALPHA_WR = 2'd0;
    localparam logic [1:0] FUNC_KEY_WR   = 2'd1;
    localparam logic [1:0] FUNC_MSG      = 2'd2;

    localparam logic [1:0] REG_ALPHABET_LENGTH = 2'd0;
    localparam logic [1:0] REG_KEY_LENGTH      = 2'd1;
    localparam logic [1:0] REG_DECRYPT_MODE    = 2'd2;

    localparam logic [6:0] ALPHABET_LENGTH_RESET = 7'd26;
    localparam logic [6:0] KEY_LENGTH_RESET      = 7'd1;

    localparam int AB_LANES    = 8;
    localparam int LANE_W      = $clog2(AB_LANES);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [7:0] t_byte;
    typedef logic [AB_LANES-1:0][7:0] t_row;

    typedef enum logic [1:0] {
        KIND_ALPHA_WR,
        KIND_KEY_WR,
        KIND_MSG
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [5:0] position;
        t_byte      symbol;
        logic       first;
    } t_op;

    typedef struct packed {
        logic [6:0] alphabet_length;
        logic [6:0] key_length;
        logic       decrypt_mode;
    } t_cfg;

endpackage

[design/vcac_channels.sv]
// Channel interfaces of the cipher block: message input, result output and
// configuration write. Each carries valid, ready and its payload.
// Standalone; used by the front part and the top level.
`timescale 1ns / 1ps

interface vcac_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [5:0] position;
    logic [7:0] symbol;
    logic       first;

    modport source (output valid, func, position, symbol, first, input ready);
    modport sink (input valid, func, position, symbol, first, output ready);
endinterface

interface vcac_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol_out;
    logic       error;

    modport source (output valid, symbol_out, error, input ready);
    modport sink (input valid, symbol_out, error, output ready);
endinterface

interface vcac_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [6:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[design/vcac_front.sv]
// Front part of the cipher: accepts input beats, classifies them and drops
// codes and table writes that have no effect. Depends on vcac_pkg and vcac_in_if.
`timescale 1ns / 1ps

module vcac_front
    import vcac_pkg::*;
#(
    parameter int ALPHABET_SIZE = 64,
    parameter int KEY_SIZE      = 64
) (
    vcac_in_if.sink i_in,
    input  logic    i_push_ready,
    output logic    o_push_valid,
    output t_op     o_push_op
);

    logic keep;

    always_comb begin
        o_push_op.position = i_in.position;
        o_push_op.symbol   = i_in.symbol;
        o_push_op.first    = i_in.first;
        unique case (i_in.func)
            FUNC_ALPHA_WR: begin
                o_push_op.kind = KIND_ALPHA_WR;
                keep           = int'(i_in.position) < ALPHABET_SIZE;
            end
            FUNC_KEY_WR: begin
                o_push_op.kind = KIND_KEY_WR;
                keep           = int'(i_in.position) < KEY_SIZE;
            end
            FUNC_MSG: begin
                o_push_op.kind = KIND_MSG;
                keep           = 1'b1;
            end
            default: begin
                o_push_op.kind = KIND_MSG;
                keep           = 1'b0;
            end
        endcase
    end

    assign o_push_valid = i_in.valid && keep;
    assign i_in.ready   = i_push_ready || !keep;

endmodule

[design/vcac_queue.sv]
// Short queue between the front and back parts of the cipher.
// Holds classified operations; depends on vcac_pkg.
`timescale 1ns / 1ps

module vcac_queue
    import vcac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push_valid,
    output logic o_push_ready,
    input  t_op  i_push_op,
    output logic o_pop_valid,
    input  logic i_pop_ready,
    output t_op  o_pop_op
);

    t_op               r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = r_count != QCNT_W'(QUEUE_DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_op     = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

[design/vcac_back.sv]
// Back part of the cipher: table memories, key position, alphabet scan,
// modular add or subtract, map back and the result register. Depends on vcac_pkg.
`timescale 1ns / 1ps

module vcac_back
    import vcac_pkg::*;
#(
    parameter int ALPHABET_SIZE = 64,
    parameter int KEY_SIZE      = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cfg  i_cfg,
    input  logic  i_op_valid,
    output logic  o_op_ready,
    input  t_op   i_op,
    output logic  o_res_valid,
    input  logic  i_res_ready,
    output t_byte o_symbol_out,
    output logic  o_error
);

    localparam int AB_ROWS = (ALPHABET_SIZE + AB_LANES - 1) / AB_LANES;
    localparam int ROW_W   = (AB_ROWS > 1) ? $clog2(AB_ROWS) : 1;
    localparam int IDX_W   = ROW_W + LANE_W;
    localparam int AL_W    = $clog2(ALPHABET_SIZE + 1);
    localparam int CMP_W   = ((IDX_W > AL_W) ? IDX_W : AL_W) + 1;
    localparam int KI_W    = (KEY_SIZE > 1) ? $clog2(KEY_SIZE) : 1;
    localparam int KL_W    = $clog2(KEY_SIZE + 1);
    localparam int KC_W    = ((KI_W + 1) > KL_W) ? (KI_W + 1) : KL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_MAP,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [KI_W-1:0]   r_key_pos, n_key_pos;
    t_byte             r_msg, n_msg;
    logic [ROW_W-1:0]  r_scan_row, n_scan_row;
    logic              r_m_found, n_m_found;
    logic              r_k_found, n_k_found;
    logic [IDX_W-1:0]  r_mpos, n_mpos;
    logic [IDX_W-1:0]  r_kpos, n_kpos;
    logic [IDX_W-1:0]  r_res, n_res;
    logic              r_out_valid, n_out_valid;
    t_byte             r_out_sym, n_out_sym;
    logic              r_out_err, n_out_err;

    t_row              ab_mem [AB_ROWS];
    t_row              r_row_q;
    logic [ROW_W-1:0]  rd_row;
    logic              ab_we;
    logic [IDX_W-1:0]  ab_wr_idx;

    t_byte             key_mem [KEY_SIZE];
    t_byte             r_key_q;
    logic              key_we;
    logic              key_rd_en;
    logic [KI_W-1:0]   key_wr_addr;

    logic [AL_W-1:0]   alen;
    logic [KL_W-1:0]   klen;
    logic              pop;
    logic [KI_W-1:0]   kp_use;
    logic [KC_W-1:0]   kp_inc;
    logic [AB_LANES-1:0] hit_m;
    logic [AB_LANES-1:0] hit_k;
    logic [LANE_W-1:0] sel_m;
    logic [LANE_W-1:0] sel_k;
    logic              last_row;
    logic              both_found;
    logic [CMP_W-1:0]  m_ext, k_ext, a_ext, sum_ext, res_ext;

    always_comb begin
        if (int'(i_cfg.alphabet_length) > ALPHABET_SIZE) begin
            alen = AL_W'(ALPHABET_SIZE);
        end else begin
            alen = AL_W'(i_cfg.alphabet_length);
        end
        if (i_cfg.key_length == '0) begin
            klen = KL_W'(1);
        end else if (int'(i_cfg.key_length) > KEY_SIZE) begin
            klen = KL_W'(KEY_SIZE);
        end else begin
            klen = KL_W'(i_cfg.key_length);
        end
    end

    assign o_op_ready  = r_state == S_IDLE;
    assign pop         = i_op_valid && o_op_ready;
    assign ab_wr_idx   = IDX_W'(i_op.position);
    assign key_wr_addr = KI_W'(i_op.position);

    always_comb begin
        if (i_op.first || KC_W'(r_key_pos) >= KC_W'(klen)) begin
            kp_use = '0;
        end else begin
            kp_use = r_key_pos;
        end
        kp_inc = KC_W'(kp_use) + KC_W'(1);
    end

    always_comb begin
        hit_m = '0;
        hit_k = '0;
        for (int l = 0; l < AB_LANES; l++) begin
            if (CMP_W'({r_scan_row, LANE_W'(l)}) < CMP_W'(alen)) begin
                hit_m[l] = r_row_q[l] == r_msg;
                hit_k[l] = r_row_q[l] == r_key_q;
            end
        end
        sel_m = '0;
        sel_k = '0;
        for (int l = AB_LANES - 1; l >= 0; l--) begin
            if (hit_m[l]) begin
                sel_m = LANE_W'(l);
            end
            if (hit_k[l]) begin
                sel_k = LANE_W'(l);
            end
        end
        last_row = (CMP_W'({r_scan_row, {LANE_W{1'b0}}}) + CMP_W'(AB_LANES))
                   >= CMP_W'(alen);
    end

    always_comb begin
        m_ext   = CMP_W'(r_mpos);
        k_ext   = CMP_W'(r_kpos);
        a_ext   = CMP_W'(alen);
        sum_ext = m_ext + k_ext;
        if (i_cfg.decrypt_mode) begin
            res_ext = (m_ext >= k_ext) ? (m_ext - k_ext) : (m_ext + a_ext - k_ext);
        end else begin
            res_ext = (sum_ext >= a_ext) ? (sum_ext - a_ext) : sum_ext;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_key_pos   = r_key_pos;
        n_msg       = r_msg;
        n_scan_row  = r_scan_row;
        n_m_found   = r_m_found;
        n_k_found   = r_k_found;
        n_mpos      = r_mpos;
        n_kpos      = r_kpos;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_res_ready;
        n_out_sym   = r_out_sym;
        n_out_err   = r_out_err;
        ab_we       = 1'b0;
        key_we      = 1'b0;
        key_rd_en   = 1'b0;
        rd_row      = '0;
        both_found  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (pop) begin
                    unique case (i_op.kind)
                        KIND_ALPHA_WR: ab_we = 1'b1;
                        KIND_KEY_WR:   key_we = 1'b1;
                        default: begin
                            key_rd_en  = 1'b1;
                            n_msg      = i_op.symbol;
                            n_m_found  = 1'b0;
                            n_k_found  = 1'b0;
                            n_scan_row = '0;
                            n_key_pos  = (kp_inc >= KC_W'(klen)) ? '0 : KI_W'(kp_inc);
                            n_state    = S_SCAN;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                n_m_found = r_m_found || (|hit_m);
                n_k_found = r_k_found || (|hit_k);
                if (!r_m_found) begin
                    n_mpos = {r_scan_row, sel_m};
                end
                if (!r_k_found) begin
                    n_kpos = {r_scan_row, sel_k};
                end
                both_found = n_m_found && n_k_found;
                if (both_found) begin
                    n_state = S_CALC;
                end else if (last_row) begin
                    n_state = S_OUT;
                end else begin
                    n_scan_row = r_scan_row + ROW_W'(1);
                    rd_row     = n_scan_row;
                end
            end
            S_CALC: begin
                n_res   = IDX_W'(res_ext);
                n_state = S_MAP;
            end
            S_MAP: begin
                rd_row  = r_res[IDX_W-1:LANE_W];
                n_state = S_OUT;
            end
            S_OUT: begin
                rd_row = r_res[IDX_W-1:LANE_W];
                if (!r_out_valid || i_res_ready) begin
                    n_out_valid = 1'b1;
                    if (r_m_found && r_k_found) begin
                        n_out_sym = r_row_q[r_res[LANE_W-1:0]];
                        n_out_err = 1'b0;
                    end else begin
                        n_out_sym = r_msg;
                        n_out_err = 1'b1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ab_we) begin
            ab_mem[ab_wr_idx[IDX_W-1:LANE_W]][ab_wr_idx[LANE_W-1:0]] <= i_op.symbol;
        end
        r_row_q <= ab_mem[rd_row];
    end

    always_ff @(posedge i_clk) begin
        if (key_we) begin
            key_mem[key_wr_addr] <= i_op.symbol;
        end
        if (key_rd_en) begin
            r_key_q <= key_mem[kp_use];
        end
    end

    always_ff @(posedge i_clk) begin
        r_msg      <= n_msg;
        r_scan_row <= n_scan_row;
        r_m_found  <= n_m_found;
        r_k_found  <= n_k_found;
        r_mpos     <= n_mpos;
        r_kpos     <= n_kpos;
        r_res      <= n_res;
        r_out_sym  <= n_out_sym;
        r_out_err  <= n_out_err;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_key_pos   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_key_pos   <= n_key_pos;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_res_valid  = r_out_valid;
    assign o_symbol_out = r_out_sym;
    assign o_error      = r_out_err;

    ap_calc_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CALC) |-> (r_m_found && r_k_found))
        else $error("Sum started without both alphabet positions.");

    ap_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAP) |-> (CMP_W'(r_res) < CMP_W'(alen)))
        else $error("Result position lies outside the alphabet.");

    ap_key_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (KC_W'(r_key_pos) < KC_W'(klen)))
        else $error("Key position left beyond the key length.");

    ap_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_OUT))
        else $error("Result register loaded outside the output step.");

endmodule

[design/vigenere_custom_alphabet_cipher.sv]
// Top level of the Vigenere cipher over a loadable alphabet.
// Holds the configuration registers; depends on vcac_pkg, vcac_channels,
// vcac_front, vcac_queue and vcac_back.
`timescale 1ns / 1ps

// A table write beat is taken in the idle state of the back part. A message
// symbol passes the scan, sum, map and output steps; for an effective alphabet
// length L the alphabet memory is scanned one row of eight entries per cycle
// for both the message and the key symbol; the scan stops at the row where both
// are found, and a symbol missing from the alphabet goes from the scan straight
// to the output step, with one row still scanned when L is zero. A queue of
// four entries separates input acceptance from the back part, and the result
// register lets the next beat start while a result waits. The tables need no
// clearing after reset.
module vigenere_custom_alphabet_cipher
    import vcac_pkg::*;
#(
    parameter int ALPHABET_SIZE = 64,
    parameter int KEY_SIZE      = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vcac_cfg_if.sink     i_cfg,
    vcac_in_if.sink      i_msg,
    vcac_out_if.source   o_res
);

    t_cfg r_cfg;
    logic push_valid;
    logic push_ready;
    t_op  push_op;
    logic pop_valid;
    logic pop_ready;
    t_op  pop_op;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alphabet_length <= ALPHABET_LENGTH_RESET;
            r_cfg.key_length      <= KEY_LENGTH_RESET;
            r_cfg.decrypt_mode    <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ALPHABET_LENGTH: r_cfg.alphabet_length <= i_cfg.data;
                REG_KEY_LENGTH:      r_cfg.key_length <= i_cfg.data;
                REG_DECRYPT_MODE:    r_cfg.decrypt_mode <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    vcac_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .KEY_SIZE      (KEY_SIZE)
    ) u_front (
        .i_in         (i_msg),
        .i_push_ready (push_ready),
        .o_push_valid (push_valid),
        .o_push_op    (push_op)
    );

    vcac_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_op    (push_op),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_op     (pop_op)
    );

    vcac_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .KEY_SIZE      (KEY_SIZE)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_op_valid   (pop_valid),
        .o_op_ready   (pop_ready),
        .i_op         (pop_op),
        .o_res_valid  (o_res.valid),
        .i_res_ready  (o_res.ready),
        .o_symbol_out (o_res.symbol_out),
        .o_error      (o_res.error)
    );

endmodule

[bench/vcac_checker.sv]
// Checker of the custom-alphabet Vigenere cipher: watches the configuration,
// message and result channels, predicts every result and compares it.
// Depends on vcac_pkg and the channel interfaces in vcac_channels.
`timescale 1ns / 1ps

module vcac_checker
    import vcac_pkg::*;
#(
    parameter int ALPHABET_SIZE = 64,
    parameter int KEY_SIZE      = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    vcac_cfg_if   cfg,
    vcac_in_if    msg,
    vcac_out_if   res,
    output int    o_failures,
    output int    o_outstanding
);

    typedef struct {
        t_byte symbol;
        logic  error;
    } t_cipher_out;

    t_byte       alphabet_tab [ALPHABET_SIZE];
    t_byte       key_tab [KEY_SIZE];
    int          key_pos;
    logic [6:0]  alphabet_len_reg;
    logic [6:0]  key_len_reg;
    logic        decrypt_reg;
    t_cipher_out cipher_out_q [$];

    function automatic int alphabet_index(input t_byte sym, input int len, output bit hit);
        hit = 1'b0;
        for (int i = 0; i < len; i++) begin
            if (alphabet_tab[i] == sym) begin
                hit = 1'b1;
                return i;
            end
        end
        return 0;
    endfunction

    task automatic cipher_beat(input logic [1:0] func, input logic [5:0] position,
                               input t_byte sym, input logic first);
        int          alen;
        int          klen;
        int          mpos;
        int          kpos;
        int          sum;
        bit          msg_hit;
        bit          key_hit;
        t_cipher_out result;
        case (func)
            FUNC_ALPHA_WR: begin
                alphabet_tab[position] = sym;
            end
            FUNC_KEY_WR: begin
                key_tab[position] = sym;
            end
            FUNC_MSG: begin
                alen = (alphabet_len_reg > ALPHABET_SIZE) ? ALPHABET_SIZE : int'(alphabet_len_reg);
                klen = (key_len_reg == 0) ? 1 : int'(key_len_reg);
                if (klen > KEY_SIZE) begin
                    klen = KEY_SIZE;
                end
                if (first || key_pos >= klen) begin
                    key_pos = 0;
                end
                mpos = alphabet_index(sym, alen, msg_hit);
                kpos = alphabet_index(key_tab[key_pos], alen, key_hit);
                key_pos = (key_pos + 1 >= klen) ? 0 : key_pos + 1;
                if (!msg_hit || !key_hit) begin
                    result.symbol = sym;
                    result.error  = 1'b1;
                end else begin
                    if (decrypt_reg) begin
                        sum = (mpos >= kpos) ? mpos - kpos : mpos + alen - kpos;
                    end else begin
                        sum = mpos + kpos;
                        if (sum >= alen) begin
                            sum = sum - alen;
                        end
                    end
                    result.symbol = alphabet_tab[sum];
                    result.error  = 1'b0;
                end
                cipher_out_q = {cipher_out_q, result};
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_cipher_out due;
        if (!i_rst_n) begin
            foreach (alphabet_tab[i]) alphabet_tab[i] = '0;
            foreach (key_tab[i]) key_tab[i] = '0;
            key_pos          = 0;
            alphabet_len_reg = ALPHABET_LENGTH_RESET;
            key_len_reg      = KEY_LENGTH_RESET;
            decrypt_reg      = 1'b0;
            cipher_out_q.delete();
            o_failures       = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_ALPHABET_LENGTH: alphabet_len_reg = cfg.data;
                    REG_KEY_LENGTH:      key_len_reg = cfg.data;
                    REG_DECRYPT_MODE:    decrypt_reg = cfg.data[0];
                    default: begin
                    end
                endcase
            end
            if (msg.valid && msg.ready) begin
                cipher_beat(msg.func, msg.position, msg.symbol, msg.first);
            end
            if (res.valid && res.ready) begin
                if (cipher_out_q.size() == 0) begin
                    $error("result beat with nothing expected: symbol_out %02h error %0b",
                           res.symbol_out, res.error);
                    o_failures++;
                end else begin
                    due = cipher_out_q.pop_front();
                    if (res.symbol_out !== due.symbol) begin
                        $error("symbol_out mismatch: expected %02h, actual %02h",
                               due.symbol, res.symbol_out);
                        o_failures++;
                    end
                    if (res.error !== due.error) begin
                        $error("error mismatch: expected %0b, actual %0b",
                               due.error, res.error);
                        o_failures++;
                    end
                end
            end
        end
        o_outstanding = cipher_out_q.size();
    end

endmodule

[bench/tb_vigenere_custom_alphabet_cipher.sv]
// Testbench top of the custom-alphabet Vigenere cipher: drives table loads,
// message symbols and register writes, and gives the verdict.
// Depends on vcac_pkg, vcac_channels, the block and vcac_checker.
`timescale 1ns / 1ps

module tb_vigenere_custom_alphabet_cipher;
    import vcac_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int TAB_DEPTH     = 64;
    localparam int NUM_PHASES    = 16;
    localparam int PHASE_ITEMS   = 89;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [6:0] PHASE_ALEN [11] = '{7'd26, 7'd26, 7'd64, 7'd64, 7'd1, 7'd127,
                                                7'd0, 7'd2, 7'd63, 7'd65, 7'd40};
    localparam logic [6:0] PHASE_KLEN [11] = '{7'd5, 7'd5, 7'd64, 7'd64, 7'd1, 7'd127,
                                                7'd0, 7'd3, 7'd17, 7'd100, 7'd2};
    localparam logic PHASE_DEC [11] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                        1'b0, 1'b1, 1'b0, 1'b1, 1'b0};

    logic  i_clk      = 1'b0;
    logic  i_rst_n    = 1'b0;
    logic  sink_ready = 1'b0;
    logic  steady     = 1'b0;
    int    hold_requests = 0;
    int    holds_served  = 0;
    int    hold_left     = 0;
    int    cycle_count   = 0;
    int    failures;
    int    outstanding;
    int    eff_alen = 26;
    int    eff_klen = 1;
    t_byte alpha_shadow [TAB_DEPTH];

    vcac_cfg_if cfg_if ();
    vcac_in_if  msg_if ();
    vcac_out_if res_if ();

    assign res_if.ready = sink_ready;

    vigenere_custom_alphabet_cipher uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_msg   (msg_if),
        .o_res   (res_if)
    );

    vcac_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .cfg           (cfg_if),
        .msg           (msg_if),
        .res           (res_if),
        .o_failures    (failures),
        .o_outstanding (outstanding)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("vigenere_custom_alphabet_cipher test failed");
            $finish;
        end
    end

    // A hold request stalls the result side for a long stretch so the block backs up.
    always @(negedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served <= holds_served + 1;
            hold_left    <= HOLD_CYCLES;
            sink_ready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left  <= hold_left - 1;
            sink_ready <= 1'b0;
        end else begin
            sink_ready <= steady || ($urandom_range(0, 99) >= 19);
        end
    end

    function automatic t_byte pick_symbol();
        if (eff_alen > 0 && $urandom_range(0, 99) < 88) begin
            return alpha_shadow[$urandom_range(0, eff_alen - 1)];
        end
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic send_item(input logic [1:0] func, input logic [5:0] position,
                             input t_byte sym, input logic first);
        while (!steady && $urandom_range(0, 99) < 19) begin
            msg_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        msg_if.valid    <= 1'b1;
        msg_if.func     <= func;
        msg_if.position <= position;
        msg_if.symbol   <= sym;
        msg_if.first    <= first;
        @(posedge i_clk);
        while (!msg_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic settle();
        msg_if.valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_registers(input logic [6:0] alen, input logic [6:0] klen,
                                     input logic dec);
        logic [1:0] reg_index [3];
        logic [6:0] reg_data [3];
        reg_index = '{REG_ALPHABET_LENGTH, REG_KEY_LENGTH, REG_DECRYPT_MODE};
        reg_data  = '{alen, klen, {6'd0, dec}};
        for (int r = 0; r < 3; r++) begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= reg_index[r];
            cfg_if.data  <= reg_data[r];
            @(posedge i_clk);
            while (!cfg_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        cfg_if.valid <= 1'b0;
        eff_alen = (alen > TAB_DEPTH) ? TAB_DEPTH : int'(alen);
        eff_klen = (klen == 0) ? 1 : ((klen > TAB_DEPTH) ? TAB_DEPTH : int'(klen));
    endtask

    initial begin
        logic [6:0] alen;
        logic [6:0] klen;
        logic       dec;
        int         r;
        t_byte      sym;
        logic [5:0] pos;

        cfg_if.valid    = 1'b0;
        cfg_if.index    = REG_ALPHABET_LENGTH;
        cfg_if.data     = '0;
        msg_if.valid    = 1'b0;
        msg_if.func     = FUNC_MSG;
        msg_if.position = '0;
        msg_if.symbol   = '0;
        msg_if.first    = 1'b0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Every table entry is loaded before the first message symbol.
        for (int i = 0; i < TAB_DEPTH; i++) begin
            alpha_shadow[i] = t_byte'(8'h41 + i);
            send_item(FUNC_ALPHA_WR, 6'(i), alpha_shadow[i], 1'b0);
        end
        for (int i = 0; i < TAB_DEPTH; i++) begin
            send_item(FUNC_KEY_WR, 6'(i), alpha_shadow[(7 * i + 3) % 26], 1'b0);
        end

        send_item(FUNC_MSG, 6'd0, alpha_shadow[0], 1'b1);
        send_item(FUNC_MSG, 6'd63, alpha_shadow[25], 1'b0);
        send_item(FUNC_MSG, 6'd0, 8'h00, 1'b0);
        send_item(FUNC_MSG, 6'd0, 8'hFF, 1'b1);
        alpha_shadow[0] = 8'h00;
        send_item(FUNC_ALPHA_WR, 6'd0, 8'h00, 1'b0);
        send_item(FUNC_MSG, 6'd0, 8'h00, 1'b0);
        alpha_shadow[63] = 8'hFF;
        send_item(FUNC_ALPHA_WR, 6'd63, 8'hFF, 1'b1);
        send_item(FUNC_MSG, 6'd0, 8'hFF, 1'b0);
        alpha_shadow[5] = alpha_shadow[3];
        send_item(FUNC_ALPHA_WR, 6'd5, alpha_shadow[3], 1'b0);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[3], 1'b0);
        send_item(FUNC_KEY_WR, 6'd0, 8'hC3, 1'b0);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[4], 1'b1);
        send_item(FUNC_KEY_WR, 6'd0, alpha_shadow[2], 1'b0);
        send_item(FUNC_KEY_WR, 6'd63, alpha_shadow[24], 1'b1);
        send_item(FUNC_UNUSED, 6'd63, 8'hFF, 1'b1);
        send_item(FUNC_UNUSED, 6'd0, 8'h00, 1'b0);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[10], 1'b0);
        settle();
        program_registers(7'd26, 7'd3, 1'b1);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[7], 1'b1);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[0], 1'b0);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[25], 1'b0);
        send_item(FUNC_MSG, 6'd0, alpha_shadow[12], 1'b0);

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p < 11) begin
                alen = PHASE_ALEN[p];
                klen = PHASE_KLEN[p];
                dec  = PHASE_DEC[p];
            end else begin
                alen = 7'($urandom_range(1, 64));
                klen = 7'($urandom_range(1, 64));
                dec  = 1'($urandom_range(0, 1));
            end
            program_registers(alen, klen, dec);
            steady <= (p == 4 || p == 5);
            if (p == 2 || p == 9) begin
                hold_requests <= hold_requests + 1;
            end
            for (int k = 0; k < eff_klen && k < 6; k++) begin
                send_item(FUNC_KEY_WR, 6'(k), pick_symbol(), 1'($urandom_range(0, 1)));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    pos = 6'($urandom_range(0, TAB_DEPTH - 1));
                    sym = $urandom_range(0, 1) ? t_byte'($urandom_range(0, 255))
                                               : alpha_shadow[$urandom_range(0, TAB_DEPTH - 1)];
                    alpha_shadow[pos] = sym;
                    send_item(FUNC_ALPHA_WR, pos, sym, 1'($urandom_range(0, 1)));
                end else if (r < 14) begin
                    pos = ($urandom_range(0, 99) < 70) ? 6'($urandom_range(0, eff_klen - 1))
                                                       : 6'($urandom_range(0, TAB_DEPTH - 1));
                    send_item(FUNC_KEY_WR, pos, pick_symbol(), 1'($urandom_range(0, 1)));
                end else if (r < 17) begin
                    send_item(FUNC_UNUSED, 6'($urandom_range(0, 63)),
                              t_byte'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
                end else begin
                    send_item(FUNC_MSG, 6'($urandom_range(0, 63)), pick_symbol(),
                              $urandom_range(0, 99) < 8);
                end
            end
        end

        settle();
        if (failures == 0) begin
            $display("vigenere_custom_alphabet_cipher test passed");
        end else begin
            $display("vigenere_custom_alphabet_cipher test failed");
        end
        $finish;
    end

endmodule

[sim.f]
design/vcac_pkg.sv
design/vcac_channels.sv
design/vcac_front.sv
design/vcac_queue.sv
design/vcac_back.sv
design/vigenere_custom_alphabet_cipher.sv
bench/vcac_checker.sv
bench/tb_vigenere_custom_alphabet_cipher.sv
